// ===== rtl/core/sclb_pkg.sv =====
package sclb_pkg;

  localparam int LUT_SIZE = 256;

  // Configuration register map (word index)
  localparam int CFG_COUNT = 8;
  localparam int PADDR_W = 5;
  localparam logic [2:0] REG_MIN_A    = 3'd0;
  localparam logic [2:0] REG_MAX_A    = 3'd1;
  localparam logic [2:0] REG_MIN_B    = 3'd2;
  localparam logic [2:0] REG_MAX_B    = 3'd3;
  localparam logic [2:0] REG_CENTER_A = 3'd4;
  localparam logic [2:0] REG_CENTER_B = 3'd5;
  localparam logic [2:0] REG_THIRTY_A = 3'd6;
  localparam logic [2:0] REG_SIXTY_A  = 3'd7;

  localparam logic [15:0] RST_MIN_A    = 16'd0;
  localparam logic [15:0] RST_MAX_A    = 16'd65535;
  localparam logic [15:0] RST_MIN_B    = 16'd0;
  localparam logic [15:0] RST_MAX_B    = 16'd65535;
  localparam logic [15:0] RST_CENTER_A = 16'd32768;
  localparam logic [15:0] RST_CENTER_B = 16'd32768;
  localparam logic [15:0] RST_THIRTY_A = 16'd49152;
  localparam logic [15:0] RST_SIXTY_A  = 16'd57344;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TABLE  = 1'b1;

  localparam logic [1:0] REGION_B_ONLY = 2'd0;
  localparam logic [1:0] REGION_A_ONLY = 2'd1;
  localparam logic [1:0] REGION_BLEND  = 2'd2;

  // Table half select: bit 0 of table_select, bit 1 picks the sensor
  localparam logic HALF_POS = 1'b0;
  localparam logic HALF_NEG = 1'b1;
  localparam logic SIDE_A   = 1'b0;
  localparam logic SIDE_B   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] sample_a;
    logic [15:0] sample_b;
    logic [1:0]  table_select;
    logic [8:0]  table_index;
    logic [15:0] table_value;
  } in_t;

  typedef struct packed {
    logic [15:0] angle;
    logic [1:0]  region;
    logic [15:0] angle_from_a;
    logic [15:0] angle_from_b;
  } out_t;

endpackage

// ===== rtl/core/sclb_div.sv =====
module sclb_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag,
  output logic          vout,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [TW-1:0] tag_out
);

  // One quotient bit per stage, restoring form; num < den * 2**QW
  logic [DW-1:0] r_s [QW+1];
  logic [QW-1:0] l_s [QW+1];
  logic [QW-1:0] q_s [QW+1];
  logic [DW-1:0] d_s [QW+1];
  logic [TW-1:0] t_s [QW+1];
  logic          v_s [QW+1];

  assign r_s[0] = DW'(num >> QW);
  assign l_s[0] = num[QW-1:0];
  assign q_s[0] = '0;
  assign d_s[0] = den;
  assign t_s[0] = tag;
  assign v_s[0] = vin;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;

    assign trial = {r_s[k], l_s[k][QW-1]};
    assign ge    = trial >= {1'b0, d_s[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else if (en) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_s[k+1] <= ge ? DW'(trial - {1'b0, d_s[k]}) : DW'(trial);
        l_s[k+1] <= QW'({l_s[k], 1'b0});
        q_s[k+1] <= QW'({q_s[k], ge});
        d_s[k+1] <= d_s[k];
        t_s[k+1] <= t_s[k];
      end
    end
  end

  assign vout    = v_s[QW];
  assign quo     = q_s[QW];
  assign rem     = r_s[QW];
  assign tag_out = t_s[QW];

endmodule

// ===== rtl/core/sclb_lut.sv =====
module sclb_lut #(
  parameter int LUT_SIZE = sclb_pkg::LUT_SIZE,
  parameter int AW = $clog2(LUT_SIZE + 1)
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic          wsel,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          rsel,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [15:0]   rdata0,
  output logic [15:0]   rdata1
);

  // Positive and negative half-wave tables of one sensor
  logic [15:0] mem [2][LUT_SIZE+1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wsel][waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata0 <= mem[rsel][raddr0];
      rdata1 <= mem[rsel][raddr1];
    end
  end

endmodule

// ===== rtl/core/sincos_angle_lut_blend.sv =====
// Channel   Dir  Handshake              Payload
// item      in   item_valid/item_ready  sclb_pkg::in_t  (sample pair or table write)
// result    out  result_valid/result_ready sclb_pkg::out_t (angle, region, sensor angles)
// config    in   APB psel/penable/pwrite 8 x 16-bit registers at 4*i, pready tied high
//
// One item enters per cycle while no result is stalled; each item passes through a
// chain of bit-per-stage dividers: blend weight (25 stages), table index
// (clog2(LUT_SIZE+1) stages), interpolation step (16).
// Table writes take effect at the table read stage, so items see writes in order.
// Reset (rst, synchronous) clears all stage valids and loads register defaults;
// tables are not cleared. A stalled result freezes the whole pipeline.
module sincos_angle_lut_blend #(
  parameter int LUT_SIZE = sclb_pkg::LUT_SIZE
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  sclb_pkg::in_t                item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output sclb_pkg::out_t               result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sclb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int LW  = $clog2(LUT_SIZE + 1);
  localparam int NWL = 16 + LW;

  typedef struct packed {
    logic           is_write;
    logic [1:0]     wsel;
    logic [LW-1:0]  widx;
    logic [15:0]    wval;
    logic           wok;
    logic [1:0]     region;
    logic           sel_a;
    logic           sel_b;
    logic [NWL-1:0] num_a;
    logic [15:0]    den_a;
    logic [NWL-1:0] num_b;
    logic [15:0]    den_b;
    logic           alpha_neg;
  } front_t;

  typedef struct packed {
    logic          is_write;
    logic [1:0]    wsel;
    logic [LW-1:0] widx;
    logic [15:0]   wval;
    logic          wok;
    logic [1:0]    region;
    logic          sel_a;
    logic [23:0]   alpha;
    logic [15:0]   den_a;
  } look_t;

  typedef struct packed {
    logic        sel_b;
    logic [15:0] den_b;
  } lookb_t;

  typedef struct packed {
    logic        neg;
    logic [15:0] base;
    logic [1:0]  region;
    logic [23:0] alpha;
  } stepa_t;

  typedef struct packed {
    logic        neg;
    logic [15:0] base;
  } stepb_t;

  // Saturate sample - lo into 0..rng
  function automatic logic [15:0] sat_off(input logic [15:0] smp, input logic [15:0] lo,
                                          input logic [15:0] rng);
    logic [16:0] d;
    d = {1'b0, smp} - {1'b0, lo};
    if (d[16]) begin
      return '0;
    end else if (d[15:0] > rng) begin
      return rng;
    end
    return d[15:0];
  endfunction

  logic en;
  assign en = !result_valid || result_ready;
  assign item_ready = en;

  // ---------------- configuration registers ----------------
  logic [15:0] cfg [sclb_pkg::CFG_COUNT];
  logic [2:0]  cfg_idx;
  assign cfg_idx = paddr[4:2];
  assign pready  = 1'b1;
  assign prdata  = {16'b0, cfg[cfg_idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[sclb_pkg::REG_MIN_A]    <= sclb_pkg::RST_MIN_A;
      cfg[sclb_pkg::REG_MAX_A]    <= sclb_pkg::RST_MAX_A;
      cfg[sclb_pkg::REG_MIN_B]    <= sclb_pkg::RST_MIN_B;
      cfg[sclb_pkg::REG_MAX_B]    <= sclb_pkg::RST_MAX_B;
      cfg[sclb_pkg::REG_CENTER_A] <= sclb_pkg::RST_CENTER_A;
      cfg[sclb_pkg::REG_CENTER_B] <= sclb_pkg::RST_CENTER_B;
      cfg[sclb_pkg::REG_THIRTY_A] <= sclb_pkg::RST_THIRTY_A;
      cfg[sclb_pkg::REG_SIXTY_A]  <= sclb_pkg::RST_SIXTY_A;
    end else if (psel && penable && pwrite) begin
      cfg[cfg_idx] <= pwdata[15:0];
    end
  end

  // ---------------- front stage: classify, saturate, set up divides ----------------
  logic [15:0]        fa, fb, ca, ta, sa;
  logic signed [18:0] a19, s19, t19, c2, lo_s, lo_t;
  logic [15:0]        rng_a, rng_b, off_a, off_b, d16, h16;
  logic [16:0]        dev17, den17, nmag17;
  logic [17:0]        half18, dn18;
  logic [15:0]        dmag16;
  front_t             f;
  logic [24:0]        f_anum;
  logic [15:0]        f_aden;

  assign fa = item.sample_a;
  assign fb = item.sample_b;
  assign ca = cfg[sclb_pkg::REG_CENTER_A];
  assign ta = cfg[sclb_pkg::REG_THIRTY_A];
  assign sa = cfg[sclb_pkg::REG_SIXTY_A];

  // Thresholds mirror around center_a and may leave the 16-bit range
  assign a19  = {3'b0, fa};
  assign s19  = {3'b0, sa};
  assign t19  = {3'b0, ta};
  assign c2   = {2'b0, ca, 1'b0};
  assign lo_s = c2 - s19;
  assign lo_t = c2 - t19;

  assign rng_a = cfg[sclb_pkg::REG_MAX_A] - cfg[sclb_pkg::REG_MIN_A];
  assign rng_b = cfg[sclb_pkg::REG_MAX_B] - cfg[sclb_pkg::REG_MIN_B];
  assign off_a = sat_off(fa, cfg[sclb_pkg::REG_MIN_A], rng_a);
  assign off_b = sat_off(fb, cfg[sclb_pkg::REG_MIN_B], rng_b);

  // Blend weight numerator |a - center| - (thirty - center), scaled by 256
  assign d16    = fa - ca;
  assign dev17  = {1'b0, d16[15] ? 16'(16'd0 - d16) : d16};
  assign h16    = ta - ca;
  assign half18 = {{2{h16[15]}}, h16};
  assign dn18   = {1'b0, dev17} - half18;
  assign den17  = {1'b0, sa} - {1'b0, ta};
  assign nmag17 = dn18[17] ? 17'(18'd0 - dn18) : dn18[16:0];
  assign dmag16 = den17[16] ? 16'(17'd0 - den17) : den17[15:0];

  always_comb begin
    f.is_write = item.kind == sclb_pkg::KIND_TABLE;
    f.wsel     = item.table_select;
    f.widx     = LW'(item.table_index);
    f.wval     = item.table_value;
    f.wok      = 32'(item.table_index) <= 32'(LUT_SIZE);
    if (a19 >= s19 || a19 <= lo_s) begin
      f.region = sclb_pkg::REGION_B_ONLY;
    end else if (a19 <= t19 && a19 >= lo_t) begin
      f.region = sclb_pkg::REGION_A_ONLY;
    end else begin
      f.region = sclb_pkg::REGION_BLEND;
    end
    f.sel_a     = (fb < cfg[sclb_pkg::REG_CENTER_B]) ? sclb_pkg::HALF_NEG : sclb_pkg::HALF_POS;
    f.sel_b     = (fa < ca) ? sclb_pkg::HALF_NEG : sclb_pkg::HALF_POS;
    // A zero range keeps offset zero; divide by one so the lookup lands on entry 0
    f.num_a     = NWL'(off_a) * NWL'(LUT_SIZE);
    f.den_a     = (rng_a == 16'd0) ? 16'd1 : rng_a;
    f.num_b     = NWL'(off_b) * NWL'(LUT_SIZE);
    f.den_b     = (rng_b == 16'd0) ? 16'd1 : rng_b;
    f.alpha_neg = dn18[17] ^ den17[16];
    if (den17 == 17'd0) begin
      f_anum = '0;
      f_aden = 16'd1;
    end else begin
      f_anum = {nmag17, 8'b0};
      f_aden = dmag16;
    end
  end

  logic        s0v;
  front_t      s0;
  logic [24:0] s0_anum;
  logic [15:0] s0_aden;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0v <= 1'b0;
    end else if (en) begin
      s0v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0      <= f;
      s0_anum <= f_anum;
      s0_aden <= f_aden;
    end
  end

  // ---------------- blend weight divide ----------------
  logic        av;
  logic [24:0] aq;
  front_t      at;

  sclb_div #(.NW(25), .DW(16), .QW(25), .TW($bits(front_t))) u_div_alpha (
    .clk(clk), .rst(rst), .en(en), .vin(s0v), .num(s0_anum), .den(s0_aden), .tag(s0),
    .vout(av), .quo(aq), .rem(), .tag_out(at)
  );

  // Only the low 24 bits of the weight reach the 16 angle bits after the shift
  look_t  la_in;
  lookb_t lb_in;
  always_comb begin
    la_in.is_write = at.is_write;
    la_in.wsel     = at.wsel;
    la_in.widx     = at.widx;
    la_in.wval     = at.wval;
    la_in.wok      = at.wok;
    la_in.region   = at.region;
    la_in.sel_a    = at.sel_a;
    la_in.alpha    = at.alpha_neg ? 24'(24'd0 - aq[23:0]) : aq[23:0];
    la_in.den_a    = at.den_a;
    lb_in.sel_b    = at.sel_b;
    lb_in.den_b    = at.den_b;
  end

  // ---------------- table index divides ----------------
  logic          iva;
  logic [LW-1:0] iqa, iqb;
  logic [15:0]   ifa, ifb;
  look_t         ita;
  lookb_t        itb;

  sclb_div #(.NW(NWL), .DW(16), .QW(LW), .TW($bits(look_t))) u_div_idx_a (
    .clk(clk), .rst(rst), .en(en), .vin(av), .num(at.num_a), .den(at.den_a), .tag(la_in),
    .vout(iva), .quo(iqa), .rem(ifa), .tag_out(ita)
  );

  sclb_div #(.NW(NWL), .DW(16), .QW(LW), .TW($bits(lookb_t))) u_div_idx_b (
    .clk(clk), .rst(rst), .en(en), .vin(av), .num(at.num_b), .den(at.den_b), .tag(lb_in),
    .vout(), .quo(iqb), .rem(ifb), .tag_out(itb)
  );

  // ---------------- table read / write ----------------
  logic          we_a, we_b;
  logic [LW-1:0] a1_a, a1_b;
  logic [15:0]   d0a, d1a, d0b, d1b;

  assign we_a = en && iva && ita.is_write && ita.wok && (ita.wsel[1] == sclb_pkg::SIDE_A);
  assign we_b = en && iva && ita.is_write && ita.wok && (ita.wsel[1] == sclb_pkg::SIDE_B);
  // With a zero fraction (last entry, zero range) the neighbor adds nothing: reread the base
  assign a1_a = (iqa == LW'(LUT_SIZE) || ifa == 16'd0) ? iqa : LW'(iqa + 1'b1);
  assign a1_b = (iqb == LW'(LUT_SIZE) || ifb == 16'd0) ? iqb : LW'(iqb + 1'b1);

  sclb_lut #(.LUT_SIZE(LUT_SIZE)) u_lut_a (
    .clk(clk), .en(en), .we(we_a), .wsel(ita.wsel[0]), .waddr(ita.widx), .wdata(ita.wval),
    .rsel(ita.sel_a), .raddr0(iqa), .raddr1(a1_a), .rdata0(d0a), .rdata1(d1a)
  );

  sclb_lut #(.LUT_SIZE(LUT_SIZE)) u_lut_b (
    .clk(clk), .en(en), .we(we_b), .wsel(ita.wsel[0]), .waddr(ita.widx), .wdata(ita.wval),
    .rsel(itb.sel_b), .raddr0(iqb), .raddr1(a1_b), .rdata0(d0b), .rdata1(d1b)
  );

  logic        rv;
  logic [1:0]  rregion;
  logic [23:0] ralpha;
  logic [15:0] rfrac_a, rrng_a, rfrac_b, rrng_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if (en) begin
      rv <= iva && !ita.is_write;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rregion <= ita.region;
      ralpha  <= ita.alpha;
      rfrac_a <= ifa;
      rrng_a  <= ita.den_a;
      rfrac_b <= ifb;
      rrng_b  <= itb.den_b;
    end
  end

  // ---------------- interpolation product ----------------
  logic [15:0] dlt_a, dlt_b, mag_a, mag_b;
  assign dlt_a = d1a - d0a;
  assign dlt_b = d1b - d0b;
  assign mag_a = dlt_a[15] ? 16'(16'd0 - dlt_a) : dlt_a;
  assign mag_b = dlt_b[15] ? 16'(16'd0 - dlt_b) : dlt_b;

  logic        mv;
  logic [31:0] mprod_a, mprod_b;
  logic [15:0] mrng_a, mrng_b;
  stepa_t      msa;
  stepb_t      msb;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (en) begin
      mv <= rv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mprod_a    <= 32'(mag_a) * 32'(rfrac_a);
      mprod_b    <= 32'(mag_b) * 32'(rfrac_b);
      mrng_a     <= rrng_a;
      mrng_b     <= rrng_b;
      msa.neg    <= dlt_a[15];
      msa.base   <= d0a;
      msa.region <= rregion;
      msa.alpha  <= ralpha;
      msb.neg    <= dlt_b[15];
      msb.base   <= d0b;
    end
  end

  // ---------------- interpolation step divides ----------------
  logic        sv;
  logic [15:0] sqa, sqb;
  stepa_t      sta;
  stepb_t      stb;

  sclb_div #(.NW(32), .DW(16), .QW(16), .TW($bits(stepa_t))) u_div_step_a (
    .clk(clk), .rst(rst), .en(en), .vin(mv), .num(mprod_a), .den(mrng_a), .tag(msa),
    .vout(sv), .quo(sqa), .rem(), .tag_out(sta)
  );

  sclb_div #(.NW(32), .DW(16), .QW(16), .TW($bits(stepb_t))) u_div_step_b (
    .clk(clk), .rst(rst), .en(en), .vin(mv), .num(mprod_b), .den(mrng_b), .tag(msb),
    .vout(), .quo(sqb), .rem(), .tag_out(stb)
  );

  // ---------------- sensor angles ----------------
  logic        lv;
  logic [15:0] lang_a, lang_b;
  logic [1:0]  lregion;
  logic [23:0] lalpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      lv <= 1'b0;
    end else if (en) begin
      lv <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lang_a  <= sta.base + (sta.neg ? 16'(16'd0 - sqa) : sqa);
      lang_b  <= stb.base + (stb.neg ? 16'(16'd0 - sqb) : sqb);
      lregion <= sta.region;
      lalpha  <= sta.alpha;
    end
  end

  // ---------------- blend product ----------------
  logic [15:0] ldiff;
  assign ldiff = lang_b - lang_a;

  logic        xv;
  logic [23:0] xp;
  logic [15:0] xang_a, xang_b;
  logic [1:0]  xregion;

  always_ff @(posedge clk) begin
    if (rst) begin
      xv <= 1'b0;
    end else if (en) begin
      xv <= lv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp      <= 24'(lalpha * {{8{ldiff[15]}}, ldiff});
      xang_a  <= lang_a;
      xang_b  <= lang_b;
      xregion <= lregion;
    end
  end

  // ---------------- output register ----------------
  sclb_pkg::out_t res_next;
  always_comb begin
    res_next.region = xregion;
    unique case (xregion)
      sclb_pkg::REGION_B_ONLY: begin
        res_next.angle        = xang_b;
        res_next.angle_from_a = '0;
        res_next.angle_from_b = xang_b;
      end
      sclb_pkg::REGION_A_ONLY: begin
        res_next.angle        = xang_a;
        res_next.angle_from_a = xang_a;
        res_next.angle_from_b = '0;
      end
      default: begin
        // floor(weight * diff / 256) keeps bits 23:8 of the product
        res_next.angle        = xang_a + xp[23:8];
        res_next.angle_from_a = xang_a;
        res_next.angle_from_b = xang_b;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= xv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= res_next;
    end
  end

  // ---------------- checks ----------------
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !item_ready)
    else $error("item taken while result stalled");

  a_b_only_shape: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.region == sclb_pkg::REGION_B_ONLY) |->
      (result.angle_from_a == 16'd0 && result.angle == result.angle_from_b))
    else $error("B-only result malformed");

  a_a_only_shape: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.region == sclb_pkg::REGION_A_ONLY) |->
      (result.angle_from_b == 16'd0 && result.angle == result.angle_from_a))
    else $error("A-only result malformed");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

// ===== sim/tb_sincos_angle_lut_blend.sv =====
`timescale 1ns / 1ps

module tb_sincos_angle_lut_blend;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int HOLD_CYCLES    = 400;

  // table slots, same order as table_select
  localparam logic [1:0] TBL_A_POS = 2'd0;
  localparam logic [1:0] TBL_A_NEG = 2'd1;
  localparam logic [1:0] TBL_B_POS = 2'd2;
  localparam logic [1:0] TBL_B_NEG = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  sclb_pkg::in_t  item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  sclb_pkg::out_t result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [sclb_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sincos_angle_lut_blend dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Shadow of the block: tables, which entries hold data, and the registers.
  logic [15:0] lut_shadow [4][sclb_pkg::LUT_SIZE+1];
  bit          lut_loaded [4][sclb_pkg::LUT_SIZE+1];
  logic [15:0] cfg_shadow [sclb_pkg::CFG_COUNT];

  sclb_pkg::in_t  pending_items [$];
  sclb_pkg::out_t angle_queue [$];

  int   mismatches = 0;
  int   cycle_count = 0;
  bit   calm = 1'b0;          // no idling on either side
  logic hold_kick = 1'b0;
  int   hold_left = 0;
  int   send_gap = 0;
  int   recv_gap = 0;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("ERROR cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Queue a table write and mirror it in the shadow (writes past the end drop).
  task automatic push_table(input logic [1:0] sel, input logic [8:0] idx,
                            input logic [15:0] val);
    sclb_pkg::in_t it;
    it = '0;
    it.kind = sclb_pkg::KIND_TABLE;
    it.table_select = sel;
    it.table_index = idx;
    it.table_value = val;
    it.sample_a = 16'($urandom);
    it.sample_b = 16'($urandom);
    pending_items.push_back(it);
    if (idx <= sclb_pkg::LUT_SIZE) begin
      lut_shadow[sel][idx] = val;
      lut_loaded[sel][idx] = 1'b1;
    end
  endtask

  // Load an entry with random data before any sample reads it.
  task automatic fill_entry(input logic [1:0] sel, input longint idx);
    if (!lut_loaded[sel][idx])
      push_table(sel, 9'(idx), 16'($urandom));
  endtask

  task automatic interp_angle(input logic [1:0] sel, input logic [15:0] sample,
                              input logic [15:0] lo, input logic [15:0] hi,
                              output logic [15:0] ang);
    longint span, off, ix, fr, dl;
    span = longint'(16'(hi - lo));
    if (span == 0) begin
      fill_entry(sel, 0);
      ang = lut_shadow[sel][0];
      return;
    end
    off = longint'(sample) - longint'(lo);
    if (off < 0) off = 0;
    if (off > span) off = span;
    ix = (off * sclb_pkg::LUT_SIZE) / span;
    fr = (off * sclb_pkg::LUT_SIZE) % span;
    if (ix >= sclb_pkg::LUT_SIZE) begin
      fill_entry(sel, sclb_pkg::LUT_SIZE);
      ang = lut_shadow[sel][sclb_pkg::LUT_SIZE];
      return;
    end
    fill_entry(sel, ix);
    fill_entry(sel, ix + 1);
    dl = longint'($signed(16'(lut_shadow[sel][ix+1] - lut_shadow[sel][ix])));
    ang = 16'(longint'(lut_shadow[sel][ix]) + (dl * fr) / span);
  endtask

  // Predict the result of one sample pair, then queue it behind any table fill.
  task automatic push_sample(input logic [15:0] a, input logic [15:0] b);
    longint ca, th, sx, dev, half, den, wgt, diff;
    logic [1:0] sel_a, sel_b;
    logic [15:0] ang_a, ang_b;
    sclb_pkg::out_t exp_r;
    sclb_pkg::in_t it;
    ca = cfg_shadow[sclb_pkg::REG_CENTER_A];
    th = cfg_shadow[sclb_pkg::REG_THIRTY_A];
    sx = cfg_shadow[sclb_pkg::REG_SIXTY_A];
    sel_a = (b < cfg_shadow[sclb_pkg::REG_CENTER_B]) ? TBL_A_NEG : TBL_A_POS;
    sel_b = (a < cfg_shadow[sclb_pkg::REG_CENTER_A]) ? TBL_B_NEG : TBL_B_POS;
    exp_r = '0;
    if (longint'(a) >= sx || longint'(a) <= 2 * ca - sx) begin
      interp_angle(sel_b, b, cfg_shadow[sclb_pkg::REG_MIN_B],
                   cfg_shadow[sclb_pkg::REG_MAX_B], ang_b);
      exp_r.angle = ang_b;
      exp_r.region = sclb_pkg::REGION_B_ONLY;
      exp_r.angle_from_b = ang_b;
    end else if (longint'(a) <= th && longint'(a) >= 2 * ca - th) begin
      interp_angle(sel_a, a, cfg_shadow[sclb_pkg::REG_MIN_A],
                   cfg_shadow[sclb_pkg::REG_MAX_A], ang_a);
      exp_r.angle = ang_a;
      exp_r.region = sclb_pkg::REGION_A_ONLY;
      exp_r.angle_from_a = ang_a;
    end else begin
      interp_angle(sel_a, a, cfg_shadow[sclb_pkg::REG_MIN_A],
                   cfg_shadow[sclb_pkg::REG_MAX_A], ang_a);
      interp_angle(sel_b, b, cfg_shadow[sclb_pkg::REG_MIN_B],
                   cfg_shadow[sclb_pkg::REG_MAX_B], ang_b);
      dev  = longint'($signed(16'(a - cfg_shadow[sclb_pkg::REG_CENTER_A])));
      half = longint'($signed(16'(cfg_shadow[sclb_pkg::REG_THIRTY_A] -
                                  cfg_shadow[sclb_pkg::REG_CENTER_A])));
      if (dev < 0) dev = -dev;
      den = sx - th;
      wgt = (den != 0) ? ((dev - half) * 256) / den : 0;
      diff = longint'($signed(16'(ang_b - ang_a)));
      // weighted step rounds toward minus infinity
      exp_r.angle = 16'(longint'(ang_a) + ((wgt * diff) >>> 8));
      exp_r.region = sclb_pkg::REGION_BLEND;
      exp_r.angle_from_a = ang_a;
      exp_r.angle_from_b = ang_b;
    end
    angle_queue.push_back(exp_r);
    it = '0;
    it.kind = sclb_pkg::KIND_SAMPLE;
    it.sample_a = a;
    it.sample_b = b;
    it.table_select = 2'($urandom);
    it.table_index = 9'($urandom);
    it.table_value = 16'($urandom);
    pending_items.push_back(it);
  endtask

  // Hold until every item is in and every result out, then let the pipe empty.
  task automatic drain();
    wait (pending_items.size() == 0 && !item_valid && angle_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_shadow[idx] = val;
  endtask

  task automatic write_all(input logic [15:0] mna, input logic [15:0] mxa,
                           input logic [15:0] mnb, input logic [15:0] mxb,
                           input logic [15:0] cna, input logic [15:0] cnb,
                           input logic [15:0] thr, input logic [15:0] sxt);
    write_reg(sclb_pkg::REG_MIN_A, mna);
    write_reg(sclb_pkg::REG_MAX_A, mxa);
    write_reg(sclb_pkg::REG_MIN_B, mnb);
    write_reg(sclb_pkg::REG_MAX_B, mxb);
    write_reg(sclb_pkg::REG_CENTER_A, cna);
    write_reg(sclb_pkg::REG_CENTER_B, cnb);
    write_reg(sclb_pkg::REG_THIRTY_A, thr);
    write_reg(sclb_pkg::REG_SIXTY_A, sxt);
  endtask

  // Mostly samples; some table rewrites and writes past the last entry as noise.
  task automatic random_items(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 19);
      if (r == 0)
        push_table(2'($urandom), 9'($urandom_range(sclb_pkg::LUT_SIZE + 1, 511)),
                   16'($urandom));
      else if (r == 1)
        push_table(2'($urandom), 9'($urandom_range(0, sclb_pkg::LUT_SIZE)), 16'($urandom));
      else if (r == 2)
        push_sample(cfg_shadow[sclb_pkg::REG_CENTER_A] + 16'($urandom_range(0, 3)),
                    16'($urandom));
      else
        push_sample(16'($urandom), 16'($urandom));
    end
  endtask

  // Driver: advance to the next item once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap <= 0;
    end else if (!item_valid || item_ready) begin
      if (send_gap > 0) begin
        item_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        item_valid <= 1'b0;
        send_gap <= $urandom_range(0, 3);
      end else if (pending_items.size() > 0) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk) begin
    if (hold_kick) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Monitor: check each result against the oldest prediction, then pick next ready.
  always @(posedge clk) begin
    sclb_pkg::out_t want;
    if (!rst && result_valid && result_ready) begin
      if (angle_queue.size() == 0) begin
        report_mismatch("unexpected result angle", result.angle, 16'd0);
      end else begin
        want = angle_queue.pop_front();
        if (result.angle !== want.angle)
          report_mismatch("angle", result.angle, want.angle);
        if (result.region !== want.region)
          report_mismatch("region", 16'(result.region), 16'(want.region));
        if (result.angle_from_a !== want.angle_from_a)
          report_mismatch("angle_from_a", result.angle_from_a, want.angle_from_a);
        if (result.angle_from_b !== want.angle_from_b)
          report_mismatch("angle_from_b", result.angle_from_b, want.angle_from_b);
      end
    end
    if (rst || hold_kick || hold_left > 1) begin
      result_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      result_ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      result_ready <= 1'b0;
      recv_gap <= $urandom_range(0, 3);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("sincos_angle_lut_blend: mismatch");
      $finish;
    end
  end

  initial begin
    cfg_shadow[sclb_pkg::REG_MIN_A]    = sclb_pkg::RST_MIN_A;
    cfg_shadow[sclb_pkg::REG_MAX_A]    = sclb_pkg::RST_MAX_A;
    cfg_shadow[sclb_pkg::REG_MIN_B]    = sclb_pkg::RST_MIN_B;
    cfg_shadow[sclb_pkg::REG_MAX_B]    = sclb_pkg::RST_MAX_B;
    cfg_shadow[sclb_pkg::REG_CENTER_A] = sclb_pkg::RST_CENTER_A;
    cfg_shadow[sclb_pkg::REG_CENTER_B] = sclb_pkg::RST_CENTER_B;
    cfg_shadow[sclb_pkg::REG_THIRTY_A] = sclb_pkg::RST_THIRTY_A;
    cfg_shadow[sclb_pkg::REG_SIXTY_A]  = sclb_pkg::RST_SIXTY_A;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: defaults, writes past the end, last entry, every region and edge.
    push_table(TBL_A_POS, 9'd511, 16'hFFFF);
    push_table(TBL_B_NEG, 9'd257, 16'h1234);
    push_table(TBL_B_POS, 9'(sclb_pkg::LUT_SIZE), 16'hFFFF);
    push_sample(16'd0, 16'd0);
    push_sample(16'd65535, 16'd65535);
    push_sample(16'd32768, 16'd0);
    push_sample(16'd32767, 16'd65535);
    push_sample(16'd49152, 16'd32768);
    push_sample(16'd49153, 16'd32767);
    push_sample(16'd57344, 16'd1);
    push_sample(16'd57343, 16'd40000);
    push_sample(16'd8192, 16'd50000);
    push_sample(16'd8193, 16'd1000);
    push_sample(16'd16383, 16'd20000);
    drain();

    // Offsets below min and above max; zero divisor.
    write_all(16'd1000, 16'd60000, 16'd5000, 16'd50000,
              16'd100, 16'd27000, 16'd100, 16'd100);
    push_sample(16'd0, 16'd0);
    push_sample(16'd65535, 16'd65535);
    push_sample(16'd60000, 16'd50000);
    push_sample(16'd100, 16'd5000);
    push_sample(16'd99, 16'd4999);
    random_items(20);
    drain();

    // Zero ranges; threshold above 65535; wrapped range; negative divisor.
    write_all(16'd777, 16'd777, 16'd0, 16'd0,
              16'd65000, 16'd65535, 16'd65500, 16'd300);
    push_sample(16'd65535, 16'd0);
    push_sample(16'd0, 16'd65535);
    random_items(15);
    drain();
    write_all(16'd60000, 16'd100, 16'd65535, 16'd0,
              16'd0, 16'd0, 16'd20000, 16'd10000);
    random_items(20);
    drain();

    // Back pressure: receiver holds off while items keep coming.
    write_all(16'd2000, 16'd63000, 16'd1500, 16'd64000,
              16'd32000, 16'd33000, 16'd45000, 16'd56000);
    random_items(80);
    @(posedge clk);
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    drain();

    repeat (4) begin
      write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      random_items(30);
      drain();
    end

    // Plausible calibrations, heavy on blending.
    repeat (3) begin
      write_all(16'($urandom_range(0, 4000)), 16'($urandom_range(61000, 65535)),
                16'($urandom_range(0, 4000)), 16'($urandom_range(61000, 65535)),
                16'($urandom_range(30000, 35000)), 16'($urandom_range(30000, 35000)),
                16'($urandom_range(40000, 48000)), 16'($urandom_range(52000, 60000)));
      random_items(30);
      drain();
    end

    // Final stretch with no idling.
    calm = 1'b1;
    write_all(16'd0, 16'd65535, 16'd0, 16'd65535,
              16'd32768, 16'd32768, 16'd49152, 16'd57344);
    random_items(40);
    drain();

    if (mismatches == 0 && angle_queue.size() == 0)
      $display("sincos_angle_lut_blend: match");
    else
      $display("sincos_angle_lut_blend: mismatch");
    $finish;
  end

endmodule

// ===== sincos_angle_lut_blend.f =====
rtl/core/sclb_pkg.sv
rtl/core/sclb_div.sv
rtl/core/sclb_lut.sv
rtl/core/sincos_angle_lut_blend.sv
sim/tb_sincos_angle_lut_blend.sv
